FILE: rtl/ccrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrp_pkg
// Shared constants, types and tables for the coil combination block.
// ----------------------------------------------------------------------------
package ccrp_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_COILS   = 32;
  localparam int E_W         = 37;
  localparam int WS_W        = 53;
  localparam int OUT_W       = 19;
  localparam int CORDIC_N    = 15;
  localparam int SQRT_N      = 19;
  localparam int DIV_N       = 17;
  localparam int MUL_N       = 4;

  localparam longint unsigned E_UNIT  = 64'd1 << (2 * SAMPLE_BITS - 1);
  localparam longint unsigned E_CAP   = (64'd1 << E_W) - 64'd1;
  localparam longint unsigned E_LIM64 = (64'(MAX_COILS) > E_CAP / E_UNIT) ?
                                        E_CAP : 64'(MAX_COILS) * E_UNIT;
  localparam logic [E_W-1:0]  E_LIM   = E_LIM64[E_W-1:0];

  localparam logic [15:0] INV_GAIN = 16'd39797;
  localparam int          QUARTER  = 16384;

  typedef enum logic [3:0] {
    S_IDLE, S_VEC, S_WMUL, S_ACC, S_CHK, S_ROOT, S_RINIT, S_ROT, S_MUL, S_OUT
  } ccrp_state_t;

  typedef struct packed {
    logic       load;
    logic       vec_step;
    logic       wmul;
    logic       acc;
    logic       root_init;
    logic       sqrt_step;
    logic       div_step;
    logic       rot_init;
    logic       rot_step;
    logic       mul_step;
    logic       out_load;
    logic [4:0] idx;
  } ccrp_cmd_t;

  typedef struct packed {
    logic last;
    logic zero_e;
    logic out_busy;
  } ccrp_sts_t;

  function automatic logic [13:0] atan_f(input logic [3:0] i);
    logic [13:0] v;
    case (i)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      4'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/ccrp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrp_in_if / ccrp_out_if
// Valid/ready channels for coil samples and combined pixels.
// ----------------------------------------------------------------------------
interface ccrp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_real;
  logic signed [15:0] sample_imag;
  logic               last_coil;
  modport source (output valid, sample_real, sample_imag, last_coil, input ready);
  modport sink   (input valid, sample_real, sample_imag, last_coil, output ready);
endinterface

interface ccrp_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] combined_real;
  logic signed [18:0] combined_imag;
  logic               no_signal;
  modport source (output valid, combined_real, combined_imag, no_signal, input ready);
  modport sink   (input valid, combined_real, combined_imag, no_signal, output ready);
endinterface

FILE: rtl/coil_combine_rss_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coil_combine_rss_phase
// Root-sum-of-squares coil combination with energy-weighted phase.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one complex coil sample per transaction, all coils of a
//   pixel in a row, last_coil set on the final one. out_chan carries one
//   combined pixel per last_coil transaction; no_signal flags zero energy
//   (output then zero).
//   Each sample goes through the accept, 15 vectoring CORDIC iterations on
//   one shared shift-add unit, one weighting multiply and one accumulate.
//   A last-coil sample then adds one energy check, 19 square-root steps
//   (divider running alongside for 17), one set-up, 15 rotation iterations
//   and 4 gain-multiply steps on a 24x17 multiplier, then the output
//   register load; zero energy skips from the check straight to the load.
//   in_chan.ready is high only when the sequencer is idle.
//   Reset clears both sums and the output valid. A stalled receiver holds
//   the result in the output register; the next sample is still taken and
//   processed, and only a further result waits until the register drains.
// ----------------------------------------------------------------------------
module coil_combine_rss_phase (
  input  logic  clk,
  input  logic  rst_n,
  ccrp_in_if.sink    in_chan,
  ccrp_out_if.source out_chan
);
  import ccrp_pkg::*;

  ccrp_cmd_t cmd;
  ccrp_sts_t sts;

  ccrp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccrp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_re     (in_chan.sample_real),
    .in_im     (in_chan.sample_imag),
    .in_last   (in_chan.last_coil),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_real  (out_chan.combined_real),
    .out_imag  (out_chan.combined_imag),
    .out_nosig (out_chan.no_signal)
  );

  a_nosig_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.no_signal |->
      (out_chan.combined_real == 0) && (out_chan.combined_imag == 0))
    else $error("no_signal with non-zero pixel");
  a_one_per_tr: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("second transaction accepted while busy");
  a_rose_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> !$past(in_chan.ready))
    else $error("result appeared without a pixel in progress");

endmodule

FILE: rtl/ccrp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrp_ctrl
// Sequencer: per-coil CORDIC and accumulation, per-pixel root, divide,
// rotation and gain correction.
// ----------------------------------------------------------------------------
module ccrp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ccrp_pkg::ccrp_sts_t sts,
  output ccrp_pkg::ccrp_cmd_t cmd
);
  import ccrp_pkg::*;

  ccrp_state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_VEC;
        end
      end
      S_VEC: begin
        cmd.vec_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(CORDIC_N - 1)) state_nxt = S_WMUL;
      end
      S_WMUL: begin
        cmd.wmul  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        cnt_nxt = '0;
        if (sts.zero_e) begin
          state_nxt = S_OUT;
        end else begin
          cmd.root_init = 1'b1;
          state_nxt     = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.sqrt_step = 1'b1;
        cmd.div_step  = (cnt_r < 5'(DIV_N));
        cnt_nxt       = cnt_r + 5'd1;
        if (cnt_r == 5'(SQRT_N - 1)) state_nxt = S_RINIT;
      end
      S_RINIT: begin
        cmd.rot_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_ROT;
      end
      S_ROT: begin
        cmd.rot_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(CORDIC_N - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(MUL_N - 1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_load_vec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_VEC) && (cnt_r == 5'd0))
    else $error("load did not start vectoring");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over pending transaction");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.out_load && !cmd.acc)
    else $error("ready while busy");

endmodule

FILE: rtl/ccrp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrp_dp
// Datapath: vectoring CORDIC, energy and weighted-phase sums, radix-2
// divider, bit-pair square root, rotation CORDIC and output register.
// ----------------------------------------------------------------------------
module ccrp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ccrp_pkg::ccrp_cmd_t cmd,
  output ccrp_pkg::ccrp_sts_t sts,
  input  logic signed [15:0]  in_re,
  input  logic signed [15:0]  in_im,
  input  logic                in_last,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [18:0]  out_real,
  output logic signed [18:0]  out_imag,
  output logic                out_nosig
);
  import ccrp_pkg::*;

  function automatic logic signed [18:0] sat19(input logic signed [63:0] v);
    logic signed [18:0] r;
    if (v > 64'sd262143) r = 19'sd262143;
    else if (v < -64'sd262144) r = -19'sd262144;
    else r = v[18:0];
    return r;
  endfunction

  logic signed [15:0] re_r, im_r;
  logic               last_r, zs_r;
  logic signed [32:0] vx_r, vy_r;
  logic signed [17:0] vz_r;
  logic [31:0]        e_r;
  logic signed [48:0] prod_r;
  logic [E_W-1:0]     esum_r;
  logic signed [WS_W-1:0] wsum_r;
  logic [53:0]        rem_r;
  logic [52:0]        dvs_r;
  logic [16:0]        q_r;
  logic               qsat_r, neg_r;
  logic [E_W-1:0]     sn_r, sr_r, sb_r;
  logic signed [45:0] rx_r, ry_r;
  logic signed [17:0] rz_r;
  logic signed [63:0] macc_r;
  logic signed [18:0] cr_r, ci_r;
  logic               ov_r;
  logic signed [18:0] ore_r, oim_r;
  logic               ons_r;

  logic [3:0]         i4;
  logic signed [32:0] rex, imx, x0, y0;
  logic signed [17:0] z0, at18;
  logic signed [15:0] sq_op, ph;
  logic signed [31:0] sq_p;
  logic [E_W:0]       es_add;
  logic signed [WS_W:0] ws_add;
  logic [52:0]        aw;
  logic [53:0]        num;
  logic [E_W:0]       st;
  logic [16:0]        qv;
  logic signed [17:0] zq;
  logic [19:0]        mag;
  logic signed [45:0] xm, msrc;
  logic signed [23:0] mop;
  logic signed [40:0] pp;
  logic signed [63:0] full, rnd;

  assign i4   = cmd.idx[3:0];
  assign at18 = $signed({4'b0, atan_f(i4)});

  always_comb begin
    rex = 33'(in_re);
    imx = 33'(in_im);
    x0  = rex;
    y0  = imx;
    z0  = '0;
    if (in_re < 0) begin
      if (in_im >= 0) begin
        x0 = imx;
        y0 = -rex;
        z0 = 18'sd16384;
      end else begin
        x0 = -imx;
        y0 = rex;
        z0 = -18'sd16384;
      end
    end
  end

  assign sq_op = (cmd.idx == 5'd0) ? re_r : im_r;
  assign sq_p  = sq_op * sq_op;
  assign ph    = zs_r ? 16'sd0 : vz_r[15:0];

  assign es_add = {1'b0, esum_r} + {6'b0, e_r};
  assign ws_add = $signed({wsum_r[WS_W-1], wsum_r}) + prod_r;

  assign aw  = wsum_r[WS_W-1] ? 53'(-wsum_r) : 53'(wsum_r);
  assign num = {1'b0, aw} + 54'(esum_r >> 1);
  assign st  = {1'b0, sr_r} + {1'b0, sb_r};

  always_comb begin
    qv = qsat_r ? 17'd32768 : q_r;
    if (qv > 17'd32768) qv = 17'd32768;
    zq = neg_r ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
    if (zq > 18'sd32767) zq = 18'sd32767;
    mag = 20'(sr_r[18:0]) + 20'(sn_r > sr_r);
    xm  = $signed({2'b0, mag, 24'b0});
  end

  assign msrc = cmd.idx[1] ? ry_r : rx_r;
  assign mop  = cmd.idx[0] ? 24'($signed(msrc[45:23])) : $signed({1'b0, msrc[22:0]});
  assign pp   = mop * $signed({1'b0, INV_GAIN});
  assign full = (64'(pp) <<< 23) + macc_r;
  assign rnd  = (full + (64'sd1 <<< 39)) >>> 40;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      re_r   <= in_re;
      im_r   <= in_im;
      last_r <= in_last;
      zs_r   <= (in_re == 0) && (in_im == 0);
      vx_r   <= x0 <<< 14;
      vy_r   <= y0 <<< 14;
      vz_r   <= z0;
    end
    if (cmd.vec_step) begin
      if (vy_r >= 0) begin
        vx_r <= vx_r + (vy_r >>> i4);
        vy_r <= vy_r - (vx_r >>> i4);
        vz_r <= vz_r + at18;
      end else begin
        vx_r <= vx_r - (vy_r >>> i4);
        vy_r <= vy_r + (vx_r >>> i4);
        vz_r <= vz_r - at18;
      end
      if (cmd.idx == 5'd0) e_r <= 32'(sq_p);
      else if (cmd.idx == 5'd1) e_r <= e_r + 32'(sq_p);
    end
    if (cmd.wmul) prod_r <= $signed({1'b0, e_r}) * ph;
    if (cmd.root_init) begin
      rem_r  <= num;
      dvs_r  <= {esum_r, 16'b0};
      q_r    <= '0;
      qsat_r <= num >= {esum_r, 17'b0};
      neg_r  <= wsum_r[WS_W-1];
      sn_r   <= esum_r;
      sr_r   <= '0;
      sb_r   <= E_W'(1) << (E_W - 1);
    end
    if (cmd.div_step) begin
      if (rem_r >= {1'b0, dvs_r}) begin
        rem_r <= rem_r - {1'b0, dvs_r};
        q_r   <= {q_r[15:0], 1'b1};
      end else begin
        q_r   <= {q_r[15:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.sqrt_step) begin
      if ({1'b0, sn_r} >= st) begin
        sn_r <= sn_r - st[E_W-1:0];
        sr_r <= (sr_r >> 1) + sb_r;
      end else begin
        sr_r <= sr_r >> 1;
      end
      sb_r <= sb_r >> 2;
    end
    if (cmd.rot_init) begin
      if (zq > 18'sd16384) begin
        rx_r <= '0;
        ry_r <= xm;
        rz_r <= zq - 18'sd16384;
      end else if (zq < -18'sd16384) begin
        rx_r <= '0;
        ry_r <= -xm;
        rz_r <= zq + 18'sd16384;
      end else begin
        rx_r <= xm;
        ry_r <= '0;
        rz_r <= zq;
      end
    end
    if (cmd.rot_step) begin
      if (rz_r >= 0) begin
        rx_r <= rx_r - (ry_r >>> i4);
        ry_r <= ry_r + (rx_r >>> i4);
        rz_r <= rz_r - at18;
      end else begin
        rx_r <= rx_r + (ry_r >>> i4);
        ry_r <= ry_r - (rx_r >>> i4);
        rz_r <= rz_r + at18;
      end
    end
    if (cmd.mul_step) begin
      if (!cmd.idx[0]) macc_r <= 64'(pp);
      else if (!cmd.idx[1]) cr_r <= sat19(rnd);
      else ci_r <= sat19(rnd);
    end
  end

  // running sums and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esum_r <= '0;
      wsum_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (cmd.acc) begin
        esum_r <= (es_add > {1'b0, E_LIM}) ? E_LIM : es_add[E_W-1:0];
        if (ws_add > $signed({2'b0, {(WS_W-1){1'b1}}}))
          wsum_r <= {1'b0, {(WS_W-1){1'b1}}};
        else if (ws_add < -$signed({2'b01, {(WS_W-1){1'b0}}}))
          wsum_r <= {1'b1, {(WS_W-1){1'b0}}};
        else
          wsum_r <= ws_add[WS_W-1:0];
      end
      if (cmd.out_load) begin
        esum_r <= '0;
        wsum_r <= '0;
        ov_r   <= 1'b1;
      end else if (out_ready) begin
        ov_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ons_r <= (esum_r == '0);
      ore_r <= (esum_r == '0) ? 19'sd0 : cr_r;
      oim_r <= (esum_r == '0) ? 19'sd0 : ci_r;
    end
  end

  assign sts.last     = last_r;
  assign sts.zero_e   = (esum_r == '0);
  assign sts.out_busy = ov_r && !out_ready;

  assign out_valid = ov_r;
  assign out_real  = ore_r;
  assign out_imag  = oim_r;
  assign out_nosig = ons_r;

  a_esum_cap: assert property (@(posedge clk) disable iff (!rst_n)
    esum_r <= E_LIM)
    else $error("energy sum above limit");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (esum_r == '0) && (wsum_r == '0) && ov_r)
    else $error("sums not cleared on result");
  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rot_init |-> (sr_r[E_W-1:19] == '0))
    else $error("square root out of range");

endmodule
